// ===== rtl/qph_pkg.sv =====
// Shared constants and codes for the quadratic-probe hash table.
package qph_pkg;

    localparam int unsigned CAPACITY   = 1024;
    localparam int unsigned VALUE_BITS = 64;

    localparam int unsigned KEY_BITS   = 31;
    localparam int unsigned CMD_BITS   = 2;
    localparam int unsigned STAT_BITS  = 3;
    localparam int unsigned SLOT_BITS  = 10;
    localparam int unsigned CNT_BITS   = 11;
    localparam int unsigned CFG_BITS   = 11;
    localparam int unsigned ADDR_BITS  = 3;

    localparam logic [CFG_BITS-1:0] TABLE_SIZE_RST = CFG_BITS'(1024);

    // register index decoded from paddr
    localparam logic REG_TABLE_SIZE = 1'b0;

    localparam logic [CMD_BITS-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_BITS-1:0] CMD_SEARCH = 2'd1;
    localparam logic [CMD_BITS-1:0] CMD_CLEAR  = 2'd2;

    localparam logic [STAT_BITS-1:0] ST_STORED    = 3'd0;
    localparam logic [STAT_BITS-1:0] ST_FOUND     = 3'd1;
    localparam logic [STAT_BITS-1:0] ST_NOT_FOUND = 3'd2;
    localparam logic [STAT_BITS-1:0] ST_FULL      = 3'd3;
    localparam logic [STAT_BITS-1:0] ST_CLEARED   = 3'd4;

endpackage

// ===== rtl/qph_if.sv =====
// Request and response channel interfaces.
interface qph_req_if #(
    parameter int unsigned VALUE_BITS = qph_pkg::VALUE_BITS
);
    logic                           valid;
    logic                           ready;
    logic [qph_pkg::CMD_BITS-1:0]   command;
    logic [qph_pkg::KEY_BITS-1:0]   key;
    logic [VALUE_BITS-1:0]          value;

    modport source (output valid, command, key, value, input ready);
    modport sink   (input valid, command, key, value, output ready);
endinterface

interface qph_rsp_if #(
    parameter int unsigned VALUE_BITS = qph_pkg::VALUE_BITS
);
    logic                           valid;
    logic                           ready;
    logic [qph_pkg::STAT_BITS-1:0]  status;
    logic [VALUE_BITS-1:0]          found_value;
    logic [qph_pkg::SLOT_BITS-1:0]  slot;
    logic [qph_pkg::CNT_BITS-1:0]   probe_count;

    modport source (output valid, status, found_value, slot, probe_count, input ready);
    modport sink   (input valid, status, found_value, slot, probe_count, output ready);
endinterface

// ===== rtl/quadratic_probe_hash_table.sv =====
// Open-addressed key/value hash table with quadratic probing. Each request
// (insert, search, clear) yields one response. The front end reduces the key
// of an insert or search to its home slot with a bit-serial remainder and
// parks the job in a two-entry queue; it takes the next request only once
// that job is queued. The back end walks the probe sequence through the slot
// memory, reading, comparing and advancing for each probe. A clear sweeps
// all CAPACITY slots, one per cycle. After reset the same sweep runs before
// the first request is taken; table_size may be written during it.
// table_size must only change while the table is idle.
module quadratic_probe_hash_table #(
    parameter int unsigned CAPACITY   = qph_pkg::CAPACITY,
    parameter int unsigned VALUE_BITS = qph_pkg::VALUE_BITS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    qph_req_if.sink                        i_req,
    qph_rsp_if.source                      o_rsp,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [qph_pkg::ADDR_BITS-1:0]  paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);
    import qph_pkg::*;

    localparam int unsigned SW  = $clog2(CAPACITY);
    localparam int unsigned SZW = $clog2(CAPACITY + 1);
    localparam int unsigned JW  = CMD_BITS + KEY_BITS + VALUE_BITS + SW;
    localparam int unsigned XW  = (SZW > CFG_BITS) ? SZW : CFG_BITS;

    logic [CFG_BITS-1:0] r_table_size;
    logic [SZW-1:0]      n_size;
    logic                n_q_push;
    logic [JW-1:0]       n_q_wdata;
    logic                n_q_pop;
    logic [JW-1:0]       n_q_rdata;
    logic                n_q_full;
    logic                n_q_empty;
    logic                n_init_busy;

    // APB register: table_size at offset 0, zero wait states
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_TABLE_SIZE) ? 32'(r_table_size) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_table_size <= TABLE_SIZE_RST;
        end else if (psel && penable && pwrite && paddr[2] == REG_TABLE_SIZE) begin
            r_table_size <= pwdata[CFG_BITS-1:0];
        end
    end

    // effective modulus: zero acts as one, oversize clamps to CAPACITY
    always_comb begin
        if (r_table_size == '0) begin
            n_size = SZW'(1);
        end else if (XW'(r_table_size) > XW'(CAPACITY)) begin
            n_size = SZW'(CAPACITY);
        end else begin
            n_size = SZW'(r_table_size);
        end
    end

    qph_front #(
        .CAPACITY   (CAPACITY),
        .VALUE_BITS (VALUE_BITS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_hold   (n_init_busy),
        .i_size   (n_size),
        .i_req    (i_req),
        .i_q_full (n_q_full),
        .o_q_push (n_q_push),
        .o_q_data (n_q_wdata)
    );

    qph_fifo #(
        .WIDTH (JW)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (n_q_push),
        .i_data  (n_q_wdata),
        .i_pop   (n_q_pop),
        .o_data  (n_q_rdata),
        .o_full  (n_q_full),
        .o_empty (n_q_empty)
    );

    qph_back #(
        .CAPACITY   (CAPACITY),
        .VALUE_BITS (VALUE_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_size      (n_size),
        .i_q_empty   (n_q_empty),
        .i_q_data    (n_q_rdata),
        .o_q_pop     (n_q_pop),
        .o_init_busy (n_init_busy),
        .o_rsp       (o_rsp)
    );
endmodule

// ===== rtl/qph_front.sv =====
// Front end: takes requests, reduces key to home slot, queues the job.
module qph_front #(
    parameter int unsigned CAPACITY   = qph_pkg::CAPACITY,
    parameter int unsigned VALUE_BITS = qph_pkg::VALUE_BITS,
    localparam int unsigned SW  = $clog2(CAPACITY),
    localparam int unsigned SZW = $clog2(CAPACITY + 1),
    localparam int unsigned JW  = qph_pkg::CMD_BITS + qph_pkg::KEY_BITS + VALUE_BITS + SW
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_hold,
    input  logic [SZW-1:0]  i_size,
    qph_req_if.sink         i_req,
    input  logic            i_q_full,
    output logic            o_q_push,
    output logic [JW-1:0]   o_q_data
);
    import qph_pkg::*;

    localparam int unsigned KCW = $clog2(KEY_BITS);

    typedef enum logic [1:0] {F_IDLE, F_DIV, F_PUSH} t_fstate;

    t_fstate                r_state;
    logic [CMD_BITS-1:0]    r_cmd;
    logic [KEY_BITS-1:0]    r_key;
    logic [KEY_BITS-1:0]    r_kshift;
    logic [VALUE_BITS-1:0]  r_val;
    logic [SZW-1:0]         r_rem;
    logic [KCW-1:0]         r_kcnt;
    logic [SZW:0]           n_sh;
    logic [SZW-1:0]         n_rem;

    // one remainder bit per cycle
    always_comb begin
        n_sh = {r_rem, r_kshift[KEY_BITS-1]};
        if (n_sh >= {1'b0, i_size}) begin
            n_sh = n_sh - {1'b0, i_size};
        end
        n_rem = n_sh[SZW-1:0];
    end

    assign i_req.ready = (r_state == F_IDLE) && !i_hold;
    assign o_q_push    = (r_state == F_PUSH) && !i_q_full;
    assign o_q_data    = {r_cmd, r_key, r_val, r_rem[SW-1:0]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            case (r_state)
                F_IDLE: begin
                    if (i_req.valid && !i_hold) begin
                        r_cmd    <= i_req.command;
                        r_key    <= i_req.key;
                        r_kshift <= i_req.key;
                        r_val    <= i_req.value;
                        r_rem    <= '0;
                        r_kcnt   <= '0;
                        if (i_req.command == CMD_INSERT || i_req.command == CMD_SEARCH) begin
                            r_state <= F_DIV;
                        end else if (i_req.command == CMD_CLEAR) begin
                            r_state <= F_PUSH;
                        end
                    end
                end
                F_DIV: begin
                    r_rem    <= n_rem;
                    r_kshift <= {r_kshift[KEY_BITS-2:0], 1'b0};
                    r_kcnt   <= r_kcnt + 1'b1;
                    if (r_kcnt == KCW'(KEY_BITS - 1)) begin
                        r_state <= F_PUSH;
                    end
                end
                F_PUSH: begin
                    if (!i_q_full) begin
                        r_state <= F_IDLE;
                    end
                end
                default: r_state <= F_IDLE;
            endcase
        end
    end
endmodule

// ===== rtl/qph_fifo.sv =====
// Two-entry job queue between front and back end.
module qph_fifo #(
    parameter int unsigned WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_full,
    output logic             o_empty
);
    logic [WIDTH-1:0] r_mem [2];
    logic             r_wp;
    logic             r_rp;
    logic [1:0]       r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end
endmodule

// ===== rtl/qph_back.sv =====
// Back end: probe sequencer, slot memory, clear sweep and result register.
module qph_back #(
    parameter int unsigned CAPACITY   = qph_pkg::CAPACITY,
    parameter int unsigned VALUE_BITS = qph_pkg::VALUE_BITS,
    localparam int unsigned SW  = $clog2(CAPACITY),
    localparam int unsigned SZW = $clog2(CAPACITY + 1),
    localparam int unsigned JW  = qph_pkg::CMD_BITS + qph_pkg::KEY_BITS + VALUE_BITS + SW
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic [SZW-1:0]  i_size,
    input  logic            i_q_empty,
    input  logic [JW-1:0]   i_q_data,
    output logic            o_q_pop,
    output logic            o_init_busy,
    qph_rsp_if.source       o_rsp
);
    import qph_pkg::*;

    localparam int unsigned MW = 1 + KEY_BITS + VALUE_BITS;

    typedef enum logic [2:0] {
        B_INIT, B_IDLE, B_ISSUE, B_CHECK, B_STEP, B_CLEAR, B_DONE
    } t_bstate;

    t_bstate                r_state;
    logic [CMD_BITS-1:0]    r_cmd;
    logic [KEY_BITS-1:0]    r_key;
    logic [VALUE_BITS-1:0]  r_val;
    logic [SW-1:0]          r_slot;
    logic [SZW-1:0]         r_cnt;
    logic [SZW-1:0]         r_max;
    logic [SZW-1:0]         r_e;
    logic [SZW-1:0]         r_d;
    logic [SW-1:0]          r_clr;

    logic [STAT_BITS-1:0]   r_res_stat;
    logic [VALUE_BITS-1:0]  r_res_val;
    logic [SW-1:0]          r_res_slot;
    logic [SZW-1:0]         r_res_cnt;

    logic                   r_ov;
    logic [STAT_BITS-1:0]   r_o_stat;
    logic [VALUE_BITS-1:0]  r_o_val;
    logic [SW-1:0]          r_o_slot;
    logic [SZW-1:0]         r_o_cnt;

    logic [MW-1:0]          r_mem [CAPACITY];
    logic [MW-1:0]          r_rd;
    logic                   n_we;
    logic [SW-1:0]          n_waddr;
    logic [MW-1:0]          n_wdata;

    logic [SZW-1:0]         n_c4;
    logic [SZW:0]           n_slot_sum;
    logic [SW-1:0]          n_slot;
    logic                   n_used;
    logic [KEY_BITS-1:0]    n_rkey;
    logic                   n_out_free;

    // a + b mod size, both operands already below size
    function automatic logic [SZW-1:0] mod_add(input logic [SZW-1:0] a,
                                               input logic [SZW-1:0] b,
                                               input logic [SZW-1:0] m);
        logic [SZW:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= {1'b0, m}) begin
            s = s - {1'b0, m};
        end
        return s[SZW-1:0];
    endfunction

    // 4 mod size for sizes below 4; 4 itself otherwise
    always_comb begin
        if (i_size == SZW'(1) || i_size == SZW'(2)) begin
            n_c4 = '0;
        end else if (i_size == SZW'(3)) begin
            n_c4 = SZW'(1);
        end else begin
            n_c4 = SZW'(4);
        end
    end

    always_comb begin
        n_slot_sum = (SZW+1)'(r_slot) + {1'b0, r_d};
        if (n_slot_sum >= {1'b0, i_size}) begin
            n_slot_sum = n_slot_sum - {1'b0, i_size};
        end
        n_slot = n_slot_sum[SW-1:0];
    end

    assign n_used = r_rd[MW-1];
    assign n_rkey = r_rd[VALUE_BITS +: KEY_BITS];

    always_comb begin
        n_we    = 1'b0;
        n_waddr = r_slot;
        n_wdata = {1'b1, r_key, r_val};
        if (r_state == B_INIT || r_state == B_CLEAR) begin
            n_we    = 1'b1;
            n_waddr = r_clr;
            n_wdata = '0;
        end else if (r_state == B_CHECK && r_cmd == CMD_INSERT && !n_used) begin
            n_we = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_we) begin
            r_mem[n_waddr] <= n_wdata;
        end
        r_rd <= r_mem[r_slot];
    end

    assign o_q_pop     = (r_state == B_IDLE) && !i_q_empty;
    assign o_init_busy = (r_state == B_INIT);
    assign n_out_free  = !r_ov || o_rsp.ready;

    assign o_rsp.valid       = r_ov;
    assign o_rsp.status      = r_o_stat;
    assign o_rsp.found_value = r_o_val;
    assign o_rsp.slot        = SLOT_BITS'(r_o_slot);
    assign o_rsp.probe_count = CNT_BITS'(r_o_cnt);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_INIT;
            r_clr   <= '0;
            r_max   <= '0;
            r_ov    <= 1'b0;
        end else begin
            // B_DONE reloads the output register itself
            if (r_ov && o_rsp.ready && r_state != B_DONE) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                B_INIT: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == SW'(CAPACITY - 1)) begin
                        r_state <= B_IDLE;
                    end
                end
                B_IDLE: begin
                    if (!i_q_empty) begin
                        r_cmd  <= i_q_data[JW-1 -: CMD_BITS];
                        r_key  <= i_q_data[VALUE_BITS + SW +: KEY_BITS];
                        r_val  <= i_q_data[SW +: VALUE_BITS];
                        r_slot <= i_q_data[SW-1:0];
                        r_cnt  <= '0;
                        r_e    <= '0;
                        r_d    <= (i_size == SZW'(1)) ? '0 : SZW'(1);
                        r_clr  <= '0;
                        if (i_q_data[JW-1 -: CMD_BITS] == CMD_CLEAR) begin
                            r_state <= B_CLEAR;
                        end else begin
                            r_state <= B_ISSUE;
                        end
                    end
                end
                B_ISSUE: begin
                    r_e     <= mod_add(r_e, n_c4, i_size);
                    r_state <= B_CHECK;
                end
                B_CHECK: begin
                    r_d <= mod_add(r_d, r_e, i_size);
                    if (r_cmd == CMD_INSERT && !n_used) begin
                        r_res_stat <= ST_STORED;
                        r_res_val  <= '0;
                        r_res_slot <= r_slot;
                        r_res_cnt  <= r_cnt;
                        if (r_cnt > r_max) begin
                            r_max <= r_cnt;
                        end
                        r_state <= B_DONE;
                    end else if (r_cmd == CMD_INSERT && r_cnt == i_size) begin
                        r_res_stat <= ST_FULL;
                        r_res_val  <= '0;
                        r_res_slot <= '0;
                        r_res_cnt  <= i_size;
                        r_state    <= B_DONE;
                    end else if (r_cmd != CMD_INSERT && n_used && n_rkey == r_key) begin
                        r_res_stat <= ST_FOUND;
                        r_res_val  <= r_rd[VALUE_BITS-1:0];
                        r_res_slot <= r_slot;
                        r_res_cnt  <= r_cnt;
                        r_state    <= B_DONE;
                    end else if (r_cmd != CMD_INSERT && r_cnt == r_max) begin
                        r_res_stat <= ST_NOT_FOUND;
                        r_res_val  <= '0;
                        r_res_slot <= '0;
                        r_res_cnt  <= r_max;
                        r_state    <= B_DONE;
                    end else begin
                        r_state <= B_STEP;
                    end
                end
                B_STEP: begin
                    r_slot  <= n_slot;
                    r_cnt   <= r_cnt + 1'b1;
                    r_state <= B_ISSUE;
                end
                B_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == SW'(CAPACITY - 1)) begin
                        r_res_stat <= ST_CLEARED;
                        r_res_val  <= '0;
                        r_res_slot <= '0;
                        r_res_cnt  <= '0;
                        r_state    <= B_DONE;
                    end
                end
                B_DONE: begin
                    if (n_out_free) begin
                        r_ov     <= 1'b1;
                        r_o_stat <= r_res_stat;
                        r_o_val  <= r_res_val;
                        r_o_slot <= r_res_slot;
                        r_o_cnt  <= r_res_cnt;
                        r_state  <= B_IDLE;
                    end
                end
                default: r_state <= B_IDLE;
            endcase
        end
    end
endmodule

// ===== tb/quadratic_probe_hash_table_test.sv =====
// Self-checking testbench for the quadratic-probe hash table: insert, search and clear requests.
module quadratic_probe_hash_table_test;
    timeunit 1ns;
    timeprecision 1ps;
    import qph_pkg::*;

    // command 3 is not decoded by the block: no response, no state change
    localparam logic [CMD_BITS-1:0] CMD_INVALID = 2'd3;
    localparam int unsigned DRAIN_CYCLES = 2 * CAPACITY + 64;
    localparam int unsigned NUM_RANDOM   = 1600;

    typedef struct packed {
        logic [STAT_BITS-1:0]  status;
        logic [VALUE_BITS-1:0] found_value;
        logic [SLOT_BITS-1:0]  slot;
        logic [CNT_BITS-1:0]   probe_count;
    } hash_rsp_t;

    // Shadow copy of the table; computes the response of every accepted insert,
    // search or clear and holds them in order until the block returns them.
    class hash_table_scoreboard;
        logic [KEY_BITS-1:0]   keys [CAPACITY];
        logic [VALUE_BITS-1:0] vals [CAPACITY];
        bit                    used [CAPACITY];
        logic [CNT_BITS-1:0]   max_probes;
        logic [CFG_BITS-1:0]   table_size;
        hash_rsp_t             awaited[$];
        int                    errors;

        function new();
            table_size = TABLE_SIZE_RST;
            max_probes = '0;
            errors     = 0;
            foreach (used[i]) used[i] = 0;
        endfunction

        function int unsigned eff_size();
            if (table_size == 0) return 1;
            if (table_size > CAPACITY) return CAPACITY;
            return table_size;
        endfunction

        function int unsigned advance(int unsigned cur, int unsigned step, int unsigned size);
            longint unsigned s;
            s = step;
            return int'((longint'(cur) + 2 * s * s + 2 * s + 1) % size);
        endfunction

        // returns 1 when an insert stored its key
        function bit note_request(logic [CMD_BITS-1:0] cmd, logic [KEY_BITS-1:0] key,
                                  logic [VALUE_BITS-1:0] val);
            hash_rsp_t   r;
            int unsigned size;
            int unsigned pos;
            size = eff_size();
            pos  = key % size;
            r    = '0;
            case (cmd)
                CMD_INSERT: begin
                    r.status      = ST_FULL;
                    r.probe_count = CNT_BITS'(size);
                    for (int unsigned i = 0; i <= size; i++) begin
                        if (i > 0) pos = advance(pos, i, size);
                        if (!used[pos]) begin
                            used[pos] = 1;
                            keys[pos] = key;
                            vals[pos] = val;
                            if (i > max_probes) max_probes = CNT_BITS'(i);
                            r.status      = ST_STORED;
                            r.slot        = SLOT_BITS'(pos);
                            r.probe_count = CNT_BITS'(i);
                            break;
                        end
                    end
                end
                CMD_SEARCH: begin
                    r.status      = ST_NOT_FOUND;
                    r.probe_count = max_probes;
                    for (int unsigned i = 0; i <= max_probes; i++) begin
                        if (i > 0) pos = advance(pos, i, size);
                        if (used[pos] && keys[pos] == key) begin
                            r.status      = ST_FOUND;
                            r.found_value = vals[pos];
                            r.slot        = SLOT_BITS'(pos);
                            r.probe_count = CNT_BITS'(i);
                            break;
                        end
                    end
                end
                CMD_CLEAR: begin
                    foreach (used[i]) used[i] = 0;
                    r.status = ST_CLEARED;
                end
                default: return 0;
            endcase
            awaited.push_back(r);
            return cmd == CMD_INSERT && r.status == ST_STORED;
        endfunction

        function void check_response(hash_rsp_t got);
            hash_rsp_t exp;
            if (awaited.size() == 0) begin
                $display("%0t: unexpected response %p", $realtime, got);
                errors++;
                return;
            end
            exp = awaited.pop_front();
            if (got.status !== exp.status) begin
                $display("%0t: status exp %0d got %0d", $realtime, exp.status, got.status);
                errors++;
            end
            if (got.found_value !== exp.found_value) begin
                $display("%0t: found_value exp %h got %h", $realtime,
                         exp.found_value, got.found_value);
                errors++;
            end
            if (got.slot !== exp.slot) begin
                $display("%0t: slot exp %0d got %0d", $realtime, exp.slot, got.slot);
                errors++;
            end
            if (got.probe_count !== exp.probe_count) begin
                $display("%0t: probe_count exp %0d got %0d", $realtime,
                         exp.probe_count, got.probe_count);
                errors++;
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [ADDR_BITS-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    qph_req_if req_ch ();
    qph_rsp_if rsp_ch ();

    quadratic_probe_hash_table dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    hash_table_scoreboard sb = new();
    bit idling = 1;               // when clear, both sides run back to back
    logic [KEY_BITS-1:0] key_pool[$];

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    initial begin
        req_ch.valid   = 1'b0;
        req_ch.command = CMD_INSERT;
        req_ch.key     = '0;
        req_ch.value   = '0;
        rsp_ch.ready   = 1'b0;
    end

    // Response side: random stall ahead of each response while idling, checked at the handshake edge.
    initial begin
        int unsigned stall;
        @(posedge i_clk iff i_rst_n);
        forever begin
            stall = idling ? $urandom_range(0, 16) : 0;
            if (stall > 0) begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            rsp_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!rsp_ch.valid);
            sb.check_response('{rsp_ch.status, rsp_ch.found_value, rsp_ch.slot,
                                rsp_ch.probe_count});
        end
    end

    // One request: optional gap, then hold valid until accepted. valid stays
    // high into the next request when that one has no gap.
    task automatic send_request(logic [CMD_BITS-1:0] cmd, logic [KEY_BITS-1:0] key,
                                logic [VALUE_BITS-1:0] val);
        int unsigned gap;
        gap = idling ? $urandom_range(0, 16) : 0;
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid   <= 1'b1;
        req_ch.command <= cmd;
        req_ch.key     <= key;
        req_ch.value   <= val;
        do @(posedge i_clk); while (!req_ch.ready);
        if (sb.note_request(cmd, key, val)) begin
            key_pool.push_back(key);
            if (key_pool.size() > 256) void'(key_pool.pop_front());
        end
    endtask

    task automatic wait_drained();
        while (sb.awaited.size() != 0) @(posedge i_clk);
    endtask

    // Register write only with the table idle; drain covers a clear sweep
    // possibly started by an unanswered request.
    task automatic write_table_size(logic [CFG_BITS-1:0] size);
        req_ch.valid <= 1'b0;
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= '0;    // table_size sits at byte address 0
        pwdata  <= 32'(size);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.table_size = size;
    endtask

    function automatic logic [KEY_BITS-1:0] pick_key();
        int unsigned sz;
        sz = sb.eff_size();
        case ($urandom_range(0, 3))
            0, 1: if (key_pool.size() > 0)
                      return key_pool[$urandom_range(0, key_pool.size() - 1)];
                  else
                      return KEY_BITS'($urandom);
            2: return KEY_BITS'($urandom_range(0, 4 * sz));   // crowd the home slots
            default: return KEY_BITS'($urandom);
        endcase
    endfunction

    function automatic logic [VALUE_BITS-1:0] pick_value();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    initial begin
        int unsigned issued;
        int unsigned phase_len;
        logic [CMD_BITS-1:0] cmd;
        logic [CFG_BITS-1:0] size;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: default size 1024, collisions on the home slot, key extremes
        send_request(CMD_INSERT, '0, '1);
        send_request(CMD_INSERT, KEY_BITS'(1024), '0);
        send_request(CMD_INSERT, '1, 64'h0123_4567_89ab_cdef);
        send_request(CMD_SEARCH, KEY_BITS'(1024), '0);
        send_request(CMD_SEARCH, '1, '0);
        send_request(CMD_SEARCH, KEY_BITS'(2048), '0);         // miss
        send_request(CMD_INVALID, '1, '1);
        send_request(CMD_CLEAR, '0, '0);
        send_request(CMD_SEARCH, '0, '0);                       // miss after clear
        // size 0 acts as 1: second insert finds the table full
        write_table_size('0);
        send_request(CMD_INSERT, KEY_BITS'(5), '1);
        send_request(CMD_INSERT, KEY_BITS'(6), '1);
        send_request(CMD_SEARCH, KEY_BITS'(5), '0);
        // above capacity acts as capacity
        write_table_size('1);
        send_request(CMD_CLEAR, '0, '0);
        send_request(CMD_INSERT, KEY_BITS'(2047), 64'h8000_0000_0000_0001);
        send_request(CMD_SEARCH, KEY_BITS'(2047), '0);
        // tiny table filled past capacity
        write_table_size(CFG_BITS'(4));
        send_request(CMD_CLEAR, '0, '0);
        for (int k = 0; k < 6; k++) send_request(CMD_INSERT, KEY_BITS'(k * 4), pick_value());
        send_request(CMD_SEARCH, KEY_BITS'(8), '0);

        // random phases, each under a fresh table size
        issued = 0;
        while (issued < NUM_RANDOM) begin
            case ($urandom_range(0, 9))
                0: size = CFG_BITS'(1024);
                1: size = CFG_BITS'($urandom_range(1025, 2047));
                2: size = '0;
                3: size = CFG_BITS'(1);
                default: size = CFG_BITS'($urandom_range(2, 64));
            endcase
            write_table_size(size);
            idling = ($urandom_range(0, 3) != 0);
            phase_len = (sb.eff_size() >= 512) ? 30 : $urandom_range(40, 120);
            if ($urandom_range(0, 9) < 7) send_request(CMD_CLEAR, pick_key(), pick_value());
            for (int unsigned n = 0; n < phase_len; n++) begin
                case ($urandom_range(0, 99)) inside
                    [0:47]:  cmd = CMD_INSERT;
                    [48:91]: cmd = CMD_SEARCH;
                    [92:96]: cmd = CMD_CLEAR;
                    default: cmd = CMD_INVALID;
                endcase
                // occasionally hold off until the block has answered everything
                if ($urandom_range(0, 49) == 0) begin
                    req_ch.valid <= 1'b0;
                    wait_drained();
                end
                send_request(cmd, pick_key(), pick_value());
                if (cmd != CMD_INVALID) issued++;
            end
        end

        req_ch.valid <= 1'b0;
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.errors == 0 && sb.awaited.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // worst case: every request probing a full 1024-slot table with full stalls
    initial begin
        #200ms;
        $display("tb: failure");
        $finish;
    end

endmodule
